### rtl/core/flanger_effect_unit_defines.svh
// ----------------------------------------------------------------------------
// flanger effect unit assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef FLANGER_EFFECT_UNIT_DEFINES_SVH
`define FLANGER_EFFECT_UNIT_DEFINES_SVH

// consequent must hold on the following clock edge
`define FLNG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent must hold on the same clock edge
`define FLNG_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/core/flng_pkg.sv
// ----------------------------------------------------------------------------
// flng_pkg
// shared widths, register indexes and the |cos| lookup table of the flanger
// ----------------------------------------------------------------------------
package flng_pkg;

    // table size is a power of two, so the phase index is a plain bit slice
    localparam int COS_TABLE_SIZE = 256;
    localparam int COS_IDX_W      = $clog2(COS_TABLE_SIZE);

    // shared multiplier operand and result widths
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 17;
    localparam int MUL_R_W = 42;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_SAMPLE_WIDTH = 2'd0,
        REG_DELAY_MAX    = 2'd1,
        REG_GAIN         = 2'd2,
        REG_PHASE_STEP   = 2'd3
    } cfg_reg_t;

    typedef logic [14:0] cos_rom_t [COS_TABLE_SIZE];

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    // series divisors (2j-1)(2j) as reciprocals, exact for operands below 2^34
    localparam int TAYLOR_N  = 34;
    localparam int TAYLOR_SH = TAYLOR_N + 8;

    typedef logic [63:0] recip_t [8];

    localparam recip_t TAYLOR_RECIP = '{
        (64'd1 << TAYLOR_SH) / 64'd2   + 64'd1,
        (64'd1 << TAYLOR_SH) / 64'd12  + 64'd1,
        (64'd1 << TAYLOR_SH) / 64'd30  + 64'd1,
        (64'd1 << TAYLOR_SH) / 64'd56  + 64'd1,
        (64'd1 << TAYLOR_SH) / 64'd90  + 64'd1,
        (64'd1 << TAYLOR_SH) / 64'd132 + 64'd1,
        (64'd1 << TAYLOR_SH) / 64'd182 + 64'd1,
        (64'd1 << TAYLOR_SH) / 64'd240 + 64'd1
    };

    // one |cos| entry in Q0.15 from a Q30 Taylor series
    function automatic logic [14:0] cos_entry(input int unsigned k);
        logic [63:0]        n;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic [127:0]       wide;
        logic signed [63:0] sum;
        n = (64'(k) << 2) & 64'(2 * COS_TABLE_SIZE - 1);
        if (n > 64'(COS_TABLE_SIZE))
            n = 64'(2 * COS_TABLE_SIZE) - n;
        x    = (n * PI_Q30) >> (COS_IDX_W + 1);
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = $signed(term);
        for (int j = 1; j <= 8; j++)
        begin
            wide = 128'((term * x2) >> 30) * 128'(TAYLOR_RECIP[j - 1]);
            term = wide[TAYLOR_SH +: 64];
            if ((j & 1) == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        v = (64'(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v[14:0];
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        for (int k = 0; k < COS_TABLE_SIZE; k++)
            rom[k] = cos_entry(k);
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

### rtl/core/flng_mac.sv
// ----------------------------------------------------------------------------
// flng_mac
// shared signed multiply-accumulate unit with a registered result
// ----------------------------------------------------------------------------
module flng_mac
    import flng_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic signed [MUL_A_W-1:0]  op_a,
    input  logic signed [MUL_B_W-1:0]  op_b,
    input  logic signed [MUL_R_W-1:0]  addend,
    output logic signed [MUL_R_W-1:0]  result_reg
);

    logic signed [MUL_R_W-1:0] prod;
    logic signed [MUL_R_W-1:0] result_next;

    // product plus addend
    always_comb
    begin
        prod        = op_a * op_b;
        result_next = prod + addend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_reg <= '0;
        else if (en)
            result_reg <= result_next;
    end

endmodule

### rtl/core/flanger_effect_unit.sv
// ----------------------------------------------------------------------------
// flanger_effect_unit
// lfo modulated delay line with linear interpolation and a gained mix
// ----------------------------------------------------------------------------
// channel   dir   tdata                  tuser
// s_*       in    [15:0] sample_in       -
// m_*       out   [15:0] sample_out      [0] warming_up
// cfg_*     in    write port, index 0..3, data [31:0]
//
// one sample passes from acceptance to result through an accept step and
// seven steps of the sequencer over the shared multiplier (delay scale, two
// interpolation products, gain mix) and the single read port of the line.
// a result waiting at the output holds the final step until it is taken.
// reset is asynchronous; the line reads as zero where not yet written, kept
// by a fill count, so no clearing pass follows reset.
// LINE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module flanger_effect_unit
    import flng_pkg::*;
#(
    parameter int LINE_DEPTH = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    // sample_in [15:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // sample_out [15:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // warming_up [0]
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int SW = (AW > 12) ? AW + 1 : 13;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_D,
        ST_ADDR,
        ST_RD_B,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_G,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration
    logic              sample_width_reg;
    logic [10:0]       delay_max_reg;
    logic signed [15:0] gain_reg;
    logic [31:0]       phase_step_reg;

    // per stream state
    logic [AW-1:0]     wp_reg;
    logic [31:0]       phase_reg;
    logic [10:0]       warmup_reg;
    logic [AW:0]       fill_reg;

    // per sample working registers
    logic signed [15:0] x_reg;
    logic signed [15:0] a_reg;
    logic signed [15:0] b_reg;
    logic [7:0]         p_reg;
    logic [AW-1:0]      ib_reg;

    // delay line
    logic [15:0]        line_mem [LINE_DEPTH];
    logic [AW-1:0]      rd_addr;
    logic [15:0]        rd_q_reg;
    logic               rd_ok_reg;

    // output register
    logic               m_tvalid_reg;
    logic [15:0]        m_tdata_reg;
    logic               m_tuser_reg;

    // shared unit
    logic                       mac_en;
    logic signed [MUL_A_W-1:0]  mac_a;
    logic signed [MUL_B_W-1:0]  mac_b;
    logic signed [MUL_R_W-1:0]  mac_add;
    logic signed [MUL_R_W-1:0]  mac_res;

    logic               in_take;
    logic signed [15:0] x_in;
    logic [14:0]        cos_val;
    logic [18:0]        d_val;
    logic [10:0]        m_val;
    logic [SW-1:0]      diff_a;
    logic [SW-1:0]      diff_b;
    logic [AW-1:0]      ia_val;
    logic               out_free;
    logic signed [MUL_R_W-1:0] rounded;
    logic signed [18:0] q_val;
    logic signed [15:0] q_sat;
    logic               warm;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // input sample per selected width
    assign x_in = sample_width_reg ? $signed(s_tdata)
                                   : $signed({{8{s_tdata[7]}}, s_tdata[7:0]});

    // delay from the |cos| table and the read addresses
    always_comb
    begin
        cos_val = COS_ROM[phase_reg[31 -: COS_IDX_W]];
        d_val   = mac_res[25:7];
        m_val   = d_val[18:8];
        diff_a  = SW'(wp_reg) - SW'(m_val);
        diff_b  = diff_a - SW'(1);
        ia_val  = diff_a[AW-1:0];
    end

    // operand selection for the shared unit
    always_comb
    begin
        mac_en  = 1'b0;
        mac_a   = '0;
        mac_b   = '0;
        mac_add = '0;
        case (state_reg)
            ST_MUL_D:
            begin
                mac_en = 1'b1;
                mac_a  = MUL_A_W'($signed({1'b0, delay_max_reg}));
                mac_b  = MUL_B_W'($signed({1'b0, cos_val}));
            end
            ST_MUL_A:
            begin
                mac_en = 1'b1;
                mac_a  = MUL_A_W'(a_reg);
                mac_b  = MUL_B_W'($signed({1'b0, 9'(9'd256 - 9'(p_reg))}));
            end
            ST_MUL_B:
            begin
                mac_en  = 1'b1;
                mac_a   = MUL_A_W'(b_reg);
                mac_b   = MUL_B_W'($signed({1'b0, p_reg}));
                mac_add = mac_res;
            end
            ST_MUL_G:
            begin
                mac_en  = 1'b1;
                mac_a   = mac_res[MUL_A_W-1:0];
                mac_b   = MUL_B_W'(gain_reg);
                mac_add = MUL_R_W'(x_reg) <<< 22;
            end
            default:
            begin
                mac_en = 1'b0;
            end
        endcase
    end

    flng_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (mac_en),
        .op_a       (mac_a),
        .op_b       (mac_b),
        .addend     (mac_add),
        .result_reg (mac_res)
    );

    // divide by 2^23 toward zero, saturate, warm-up flag
    always_comb
    begin
        rounded = mac_res + (mac_res[MUL_R_W-1] ? MUL_R_W'(23'h7FFFFF) : MUL_R_W'(0));
        q_val   = rounded[MUL_R_W-1:23];
        if (sample_width_reg)
        begin
            if (q_val < -19'sd32768)
                q_sat = -16'sd32768;
            else if (q_val > 19'sd32767)
                q_sat = 16'sd32767;
            else
                q_sat = q_val[15:0];
        end
        else
        begin
            if (q_val < -19'sd128)
                q_sat = -16'sd128;
            else if (q_val > 19'sd127)
                q_sat = 16'sd127;
            else
                q_sat = q_val[15:0];
        end
        warm = (warmup_reg < delay_max_reg);
    end

    // read address of the line
    always_comb
    begin
        case (state_reg)
            ST_ADDR: rd_addr = ia_val;
            default: rd_addr = ib_reg;
        endcase
    end

    // delay line memory, written on input transaction
    always_ff @(posedge clk)
    begin
        if (in_take)
            line_mem[wp_reg] <= x_in;
        rd_q_reg <= line_mem[rd_addr];
    end

    // sequencer, counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_width_reg <= 1'b1;
            delay_max_reg    <= 11'd100;
            gain_reg         <= 16'sd16384;
            phase_step_reg   <= 32'd894785;
            wp_reg           <= '0;
            phase_reg        <= '0;
            warmup_reg       <= '0;
            fill_reg         <= '0;
            rd_ok_reg        <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            m_tuser_reg      <= 1'b0;
            m_tdata_reg      <= '0;
            x_reg            <= '0;
            a_reg            <= '0;
            b_reg            <= '0;
            p_reg            <= '0;
            ib_reg           <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SAMPLE_WIDTH: sample_width_reg <= cfg_data[0];
                    REG_DELAY_MAX:    delay_max_reg    <= cfg_data[10:0];
                    REG_GAIN:         gain_reg         <= cfg_data[15:0];
                    REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                    default:          phase_step_reg   <= phase_step_reg;
                endcase
            end

            // entries at or above the fill count read as zero
            rd_ok_reg <= ((AW + 1)'(rd_addr) < fill_reg);

            // result taken; the finishing step reloads the register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_FINISH))
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        x_reg     <= x_in;
                        if (fill_reg != (AW + 1)'(LINE_DEPTH))
                            fill_reg <= fill_reg + 1'b1;
                        state_reg <= ST_MUL_D;
                    end
                end
                ST_MUL_D:
                begin
                    state_reg <= ST_ADDR;
                end
                ST_ADDR:
                begin
                    p_reg     <= d_val[7:0];
                    ib_reg    <= diff_b[AW-1:0];
                    state_reg <= ST_RD_B;
                end
                ST_RD_B:
                begin
                    a_reg     <= rd_ok_reg ? $signed(rd_q_reg) : 16'sd0;
                    state_reg <= ST_MUL_A;
                end
                ST_MUL_A:
                begin
                    b_reg     <= rd_ok_reg ? $signed(rd_q_reg) : 16'sd0;
                    state_reg <= ST_MUL_B;
                end
                ST_MUL_B:
                begin
                    state_reg <= ST_MUL_G;
                end
                ST_MUL_G:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= warm ? 16'd0 : q_sat;
                        m_tuser_reg  <= warm;
                        if (warmup_reg != 11'd2047)
                            warmup_reg <= warmup_reg + 1'b1;
                        phase_reg    <= phase_reg + phase_step_reg;
                        wp_reg       <= wp_reg + 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### rtl/core/flng_checker.sv
// ----------------------------------------------------------------------------
// flng_checker
// port level checks of the flanger effect unit, bound to the top level
// ----------------------------------------------------------------------------
`include "flanger_effect_unit_defines.svh"

module flng_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result stays offered
    `FLNG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // a stalled result keeps its data
    `FLNG_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // warm-up results carry a zero sample
    `FLNG_ASSERT_SAME(a_warm_zero, m_tvalid && m_tuser, m_tdata == 16'd0, "warm-up result not zero")

    // an accepted sample keeps the input closed while it is worked on
    `FLNG_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "input open during work")

endmodule

bind flanger_effect_unit flng_checker u_flng_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
